// File: design/b64e_pkg.sv
// Shared types, constants and the alphabet lookup for the Base64 stream encoder.
package b64e_pkg;

  localparam int unsigned CharW   = 7;
  localparam int unsigned MaxChars = 4;
  localparam int unsigned QDepth  = 2;

  localparam logic [CharW-1:0] PadChar = 7'h3D;  // '='

  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_THIRD  = 2'd2
  } phase_e;

  // One queue entry holds every character produced by one input byte.
  typedef struct packed {
    logic [MaxChars-1:0][CharW-1:0] chars;
    logic [1:0]                     cnt_m1;   // number of characters minus one
    logic                           is_last;  // final character ends the message
  } group_entry_t;

  function automatic logic [CharW-1:0] sextet_char(input logic [5:0] s);
    logic [CharW-1:0] c;
    if (s < 6'd26) begin
      c = 7'h41 + {1'b0, s};
    end else if (s < 6'd52) begin
      c = 7'h61 + {1'b0, s} - 7'd26;
    end else if (s < 6'd62) begin
      c = 7'h30 + {1'b0, s} - 7'd52;
    end else if (s == 6'd62) begin
      c = 7'h2B;
    end else begin
      c = 7'h2F;
    end
    return c;
  endfunction

endpackage

// File: design/b64e_front.sv
// Front end: accepts bytes, tracks the group phase and builds one character group per byte.
module b64e_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic [7:0]            data_byte_i,
  input  logic                  end_of_message_i,
  output b64e_pkg::group_entry_t entry_o
);
  import b64e_pkg::*;

  phase_e     phase_q, phase_d;
  logic [3:0] left_q, left_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FIRST;
      left_q  <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      left_q  <= left_d;
    end
  end

  always_comb begin
    entry_o = '0;
    phase_d = PH_FIRST;
    left_d  = '0;
    unique case (phase_q)
      PH_SECOND: begin
        entry_o.chars[0] = sextet_char({left_q[1:0], data_byte_i[7:4]});
        if (end_of_message_i) begin
          entry_o.chars[1] = sextet_char({data_byte_i[3:0], 2'b00});
          entry_o.chars[2] = PadChar;
          entry_o.cnt_m1   = 2'd2;
          entry_o.is_last  = 1'b1;
        end else begin
          phase_d = PH_THIRD;
          left_d  = data_byte_i[3:0];
        end
      end
      PH_THIRD: begin
        entry_o.chars[0] = sextet_char({left_q, data_byte_i[7:6]});
        entry_o.chars[1] = sextet_char(data_byte_i[5:0]);
        entry_o.cnt_m1   = 2'd1;
        entry_o.is_last  = end_of_message_i;
      end
      default: begin
        entry_o.chars[0] = sextet_char(data_byte_i[7:2]);
        if (end_of_message_i) begin
          entry_o.chars[1] = sextet_char({data_byte_i[1:0], 4'b0000});
          entry_o.chars[2] = PadChar;
          entry_o.chars[3] = PadChar;
          entry_o.cnt_m1   = 2'd3;
          entry_o.is_last  = 1'b1;
        end else begin
          phase_d = PH_SECOND;
          left_d  = {2'b00, data_byte_i[1:0]};
        end
      end
    endcase
  end

endmodule

// File: design/b64e_queue.sv
// Two-entry queue of character groups between the front and back ends.
module b64e_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  b64e_pkg::group_entry_t push_entry_i,
  input  logic                   pop_i,
  output b64e_pkg::group_entry_t head_o,
  output logic                   full_o,
  output logic                   empty_o
);
  import b64e_pkg::*;

  group_entry_t mem_q [QDepth];
  logic         wr_ptr_q, rd_ptr_q;
  logic [1:0]   count_q;

  assign full_o  = (count_q == 2'(QDepth));
  assign empty_o = (count_q == 2'd0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

// File: design/b64e_back.sv
// Back end: walks the head group one character per cycle into the output register while the output is not stalled.
module b64e_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  b64e_pkg::group_entry_t head_i,
  input  logic                   empty_i,
  output logic                   pop_o,
  input  logic                   out_stall_i,
  output logic                   out_valid_o,
  output logic [b64e_pkg::CharW-1:0] out_char_o,
  output logic                   last_char_o
);
  import b64e_pkg::*;

  logic [1:0]       idx_q;
  logic             valid_q;
  logic [CharW-1:0] char_q;
  logic             last_q;
  logic             load;
  logic             at_end;

  // The output register may be refilled when it is empty or its transaction completes.
  assign load   = !empty_i && (!valid_q || !out_stall_i);
  assign at_end = (idx_q == head_i.cnt_m1);
  assign pop_o  = load && at_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q   <= at_end ? 2'd0 : idx_q + 2'd1;
      end else if (!out_stall_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= head_i.chars[idx_q];
      last_q <= head_i.is_last && at_end;
    end
  end

  assign out_valid_o = valid_q;
  assign out_char_o  = char_q;
  assign last_char_o = last_q;

endmodule

// File: design/base64_stream_encoder.sv
// Top level of the Base64 stream encoder.
// Encodes a byte stream into standard-alphabet Base64 (A-Z a-z 0-9 + /) characters, one
// character per output transaction. A byte yields one to four characters (one or two
// mid-group, up to four with padding on the byte flagged final); the final character of
// a message carries last_char_o. The output side delivers one character per cycle while
// out_stall_i is low, so the sustained rate is set by that single output register. A
// byte's group is written into the queue when the byte is taken, and its first character
// is then loaded into the output register. A two-entry queue between the byte front end
// and the character back end lets input continue while the output is stalled.
module base64_stream_encoder (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     data_byte_i,
  input  logic                           end_of_message_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [b64e_pkg::CharW-1:0]     out_char_o,
  output logic                           last_char_o
);
  import b64e_pkg::*;

  group_entry_t new_entry, head_entry;
  logic         q_full, q_empty, q_pop, accept;

  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  b64e_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .data_byte_i      (data_byte_i),
    .end_of_message_i (end_of_message_i),
    .entry_o          (new_entry)
  );

  b64e_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (accept),
    .push_entry_i (new_entry),
    .pop_i        (q_pop),
    .head_o       (head_entry),
    .full_o       (q_full),
    .empty_o      (q_empty)
  );

  b64e_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_entry),
    .empty_i     (q_empty),
    .pop_o       (q_pop),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_char_o  (out_char_o),
    .last_char_o (last_char_o)
  );

endmodule

// File: tb/sv/base64_stream_encoder_tb.sv
// Self-checking testbench for the Base64 stream encoder with random stalls and gaps.
module base64_stream_encoder_tb;
  import b64e_pkg::*;

  typedef struct packed {
    logic [CharW-1:0] code;
    logic             last;
  } b64_char_t;

  // One row of directed stimulus; typed characters are left-aligned and padded with spaces.
  typedef struct packed {
    logic [7:0]      data;
    logic            eom;
    logic [2:0]      n_typed;
    logic [0:3][7:0] typed;
  } dir_row_t;

  localparam int NumDirRows = 25;
  localparam int RandomBytes = 300;
  localparam logic [0:63][7:0] Alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic [7:0]       data_byte_i = 8'h00;
  logic             end_of_message_i = 1'b0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [CharW-1:0] out_char_o;
  logic             last_char_o;

  phase_e      enc_phase = PH_FIRST;
  logic [3:0]  carry_bits = 4'h0;
  b64_char_t   pending_chars [$];
  b64_char_t   head_char;
  int unsigned err_count = 0;
  bit          tx_burst = 1'b0;
  int unsigned stall_hold = 0;
  int unsigned stall_roll;

  dir_row_t dir_rows [NumDirRows] = '{
    '{8'h00, 1'b1, 3'd4, "AA=="},
    '{8'hFF, 1'b1, 3'd4, "/w=="},
    '{8'h00, 1'b0, 3'd1, "A   "},
    '{8'h00, 1'b1, 3'd3, "AA= "},
    '{8'hFF, 1'b0, 3'd1, "/   "},
    '{8'hFF, 1'b1, 3'd3, "/8= "},
    '{8'h00, 1'b0, 3'd1, "A   "},
    '{8'h00, 1'b0, 3'd1, "A   "},
    '{8'h00, 1'b1, 3'd2, "AA  "},
    '{8'hFF, 1'b0, 3'd1, "/   "},
    '{8'hFF, 1'b0, 3'd1, "/   "},
    '{8'hFF, 1'b1, 3'd2, "//  "},
    '{8'h4D, 1'b0, 3'd1, "T   "},
    '{8'h61, 1'b0, 3'd1, "W   "},
    '{8'h6E, 1'b1, 3'd2, "Fu  "},
    // An unflagged run that crosses group boundaries before the final byte.
    '{8'h12, 1'b0, 3'd0, "    "},
    '{8'h34, 1'b0, 3'd0, "    "},
    '{8'h56, 1'b0, 3'd0, "    "},
    '{8'h78, 1'b0, 3'd0, "    "},
    '{8'h9A, 1'b1, 3'd0, "    "},
    '{8'hAA, 1'b0, 3'd0, "    "},
    '{8'h55, 1'b0, 3'd0, "    "},
    '{8'hC3, 1'b1, 3'd0, "    "},
    '{8'hFB, 1'b0, 3'd0, "    "},
    '{8'hEF, 1'b1, 3'd0, "    "}
  };

  base64_stream_encoder DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .end_of_message_i (end_of_message_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_char_o       (out_char_o),
    .last_char_o      (last_char_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #800000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    err_count++;
  endtask

  function automatic logic [CharW-1:0] alphabet_char(input logic [5:0] sextet);
    return Alphabet[sextet][CharW-1:0];
  endfunction

  // Advances the encoder state by one byte and returns the number of characters it completes.
  function automatic int encode_byte(input logic [7:0] b, input logic eom,
                                     output logic [3:0][CharW-1:0] codes);
    int n;
    codes = '0;
    case (enc_phase)
      PH_SECOND: begin
        codes[0] = alphabet_char({carry_bits[1:0], b[7:4]});
        if (eom) begin
          codes[1] = alphabet_char({b[3:0], 2'b00});
          codes[2] = PadChar;
          n = 3;
          enc_phase = PH_FIRST;
          carry_bits = 4'h0;
        end else begin
          n = 1;
          enc_phase = PH_THIRD;
          carry_bits = b[3:0];
        end
      end
      PH_THIRD: begin
        codes[0] = alphabet_char({carry_bits, b[7:6]});
        codes[1] = alphabet_char(b[5:0]);
        n = 2;
        enc_phase = PH_FIRST;
        carry_bits = 4'h0;
      end
      default: begin
        codes[0] = alphabet_char(b[7:2]);
        if (eom) begin
          codes[1] = alphabet_char({b[1:0], 4'b0000});
          codes[2] = PadChar;
          codes[3] = PadChar;
          n = 4;
          enc_phase = PH_FIRST;
          carry_bits = 4'h0;
        end else begin
          n = 1;
          enc_phase = PH_SECOND;
          carry_bits = {2'b00, b[1:0]};
        end
      end
    endcase
    return n;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (tx_burst) begin
      return 0;
    end
    r = $urandom_range(99);
    if (r < 55) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 40);
  endfunction

  // Drives one byte, waits for its transaction, then queues the characters it should produce.
  // A nonzero n_typed replaces the predicted characters with the typed ones.
  task automatic transfer_byte(input logic [7:0] b, input logic eom,
                               input logic [2:0] n_typed, input logic [0:3][7:0] typed);
    int unsigned gap;
    int n;
    logic [3:0][CharW-1:0] codes;
    b64_char_t entry;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      data_byte_i <= 8'($urandom_range(255));
      end_of_message_i <= 1'($urandom_range(1));
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    end_of_message_i <= eom;
    do @(posedge clk_i); while (in_stall_o);
    n = encode_byte(b, eom, codes);
    if (n_typed != 0) begin
      n = n_typed;
      for (int k = 0; k < n; k++) begin
        codes[k] = typed[k][CharW-1:0];
      end
    end
    for (int k = 0; k < n; k++) begin
      entry.code = codes[k];
      entry.last = eom && (k == n - 1);
      pending_chars = {pending_chars, entry};
    end
  endtask

  always @(posedge clk_i) begin
    if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      stall_roll = $urandom_range(99);
      if (stall_roll < 40) begin
        out_stall_i <= 1'b0;
        stall_hold <= $urandom_range(4, 20);
      end else if (stall_roll < 75) begin
        out_stall_i <= 1'b1;
        stall_hold <= $urandom_range(0, 2);
      end else if (stall_roll < 95) begin
        out_stall_i <= 1'b0;
        stall_hold <= $urandom_range(0, 3);
      end else begin
        out_stall_i <= 1'b1;
        stall_hold <= $urandom_range(10, 30);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected character 0x%02h", out_char_o));
      end else begin
        head_char = pending_chars.pop_front();
        if (out_char_o !== head_char.code) begin
          report_mismatch($sformatf("out_char 0x%02h, expected 0x%02h",
                                    out_char_o, head_char.code));
        end
        if (last_char_o !== head_char.last) begin
          report_mismatch($sformatf("last_char %b, expected %b on character 0x%02h",
                                    last_char_o, head_char.last, head_char.code));
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned sent;
    int unsigned msg_len;
    int unsigned r;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < NumDirRows; i++) begin
      transfer_byte(dir_rows[i].data, dir_rows[i].eom, dir_rows[i].n_typed, dir_rows[i].typed);
    end
    // Random messages: mostly short, some long enough to cycle through many groups.
    sent = 0;
    while (sent < RandomBytes) begin
      r = $urandom_range(99);
      if (r < 60) begin
        msg_len = $urandom_range(1, 4);
      end else if (r < 90) begin
        msg_len = $urandom_range(5, 12);
      end else begin
        msg_len = $urandom_range(13, 40);
      end
      tx_burst = ($urandom_range(3) == 0);
      for (int unsigned k = 0; k < msg_len; k++) begin
        transfer_byte(8'($urandom_range(255)), k == msg_len - 1, 3'd0, '0);
      end
      sent += msg_len;
    end
    in_valid_i <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
